// File: src/identifier_rename_in_text_defines.svh
// assertion macros shared by the rename block
`ifndef IDENTIFIER_RENAME_IN_TEXT_DEFINES_SVH
`define IDENTIFIER_RENAME_IN_TEXT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IRT_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("irt check failed");

// next-cycle implication, checked out of reset
`define IRT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("irt check failed");

`endif

// File: src/irt_pkg.sv
// shared types and constants of the identifier rename block
`default_nettype none

package irt_pkg;

    localparam int NAME_MAX = 16;
    localparam int LEN_W    = $clog2(NAME_MAX + 1);

    // configuration register indexes
    localparam logic [2:0] REG_OLD_FIRST = 3'd0;
    localparam logic [2:0] REG_OLD_LAST  = 3'd1;
    localparam logic [2:0] REG_OLD_LEN   = 3'd2;
    localparam logic [2:0] REG_NEW_FIRST = 3'd3;
    localparam logic [2:0] REG_NEW_LAST  = 3'd4;
    localparam logic [2:0] REG_NEW_LEN   = 3'd5;

    // special characters
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_NUL        = 8'h00;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       replaced;
    } out_beat_t;

    // per-cell control: parallel name load, buffer write, shift toward cell 0
    typedef struct packed {
        logic load;
        logic write;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/irt_cell.sv
// one byte cell of the word chain
`default_nettype none

module irt_cell (
    input  wire logic                clk,
    input  wire irt_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]          name_byte,
    input  wire logic [7:0]          text_byte,
    input  wire logic [7:0]          next_byte,
    output logic [7:0]               cell_byte
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.load)
        begin
            byte_next = name_byte;
        end
        else if (ctrl.write)
        begin
            byte_next = text_byte;
        end
        else if (ctrl.shift)
        begin
            byte_next = next_byte;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

`default_nettype wire

// File: src/identifier_rename_in_text.sv
// top level of the whole-word identifier rename block
`default_nettype none

// Whole-word identifier rename on a byte stream. Bytes enter on the text
// channel one beat at a time and leave on the result channel; every whole
// identifier equal to the old name is replaced by the new name, while text
// after a double slash (to newline or NUL) and inside double quotes (to the
// closing quote, newline or NUL) passes untouched. A word that could still
// match is held in a chain of sixteen byte cells; when it ends it is either
// shifted out unchanged or the chain is loaded with the new name and that is
// shifted out instead. One item is worked at a time: the input is held while
// the item's result beats leave, one beat per cycle while the output stage
// has room, word bytes out of cell 0 of the chain. A byte that is held in
// the chain yields no beat when taken. A registered output stage lets the
// next byte be accepted while the last result beat still waits. Configuration
// writes are always taken and must only be issued while the block is idle;
// lengths above sixteen behave as sixteen.

module identifier_rename_in_text (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [63:0]       cfg_data,

    input  wire logic              text_valid,
    output logic                   text_ready,
    input  wire irt_pkg::in_beat_t text_beat,

    output logic                   result_valid,
    input  wire logic              result_ready,
    output irt_pkg::out_beat_t     result_beat
);

`include "identifier_rename_in_text_defines.svh"

    localparam int LW = irt_pkg::LEN_W;
    localparam logic [LW-1:0] LEN_MAX = LW'(irt_pkg::NAME_MAX);

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_STRING
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // configuration registers
    logic [63:0]   old_first_reg;
    logic [63:0]   old_last_reg;
    logic [LW-1:0] old_len_reg;
    logic [63:0]   new_first_reg;
    logic [63:0]   new_last_reg;
    logic [LW-1:0] new_len_reg;

    // lexer and sequencer state
    state_t             state_reg;
    mode_t              mode_reg;
    logic [LW-1:0]      word_len_reg;
    logic               may_match_reg;
    logic [LW-1:0]      cnt_reg;
    logic               rep_reg;
    logic               has_b_reg;
    logic [7:0]         b_reg;
    logic               out_valid_reg;
    irt_pkg::out_beat_t out_beat_reg;

    // chain of cells
    irt_pkg::cell_ctrl_t        cell_ctrl [irt_pkg::NAME_MAX];
    logic [7:0]                 cell_out  [irt_pkg::NAME_MAX];
    logic [15:0][7:0]           old_chars;
    logic [15:0][7:0]           new_chars;

    logic [LW-1:0] old_len_c;
    logic [LW-1:0] new_len_c;
    logic          text_acc;
    logic          slot_free;
    logic          push;
    logic          is_word;
    logic [7:0]    b;

    // plan of the accepted item
    mode_t         mode_v;
    logic [LW-1:0] len_v;
    logic          mm_v;
    logic [LW-1:0] cnt_v;
    logic          rep_v;
    logic          hasb_v;
    logic          write_v;
    logic          load_v;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_first_reg <= '0;
            old_last_reg  <= '0;
            old_len_reg   <= LW'(1);
            new_first_reg <= '0;
            new_last_reg  <= '0;
            new_len_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                irt_pkg::REG_OLD_FIRST: old_first_reg <= cfg_data;
                irt_pkg::REG_OLD_LAST:  old_last_reg  <= cfg_data;
                irt_pkg::REG_OLD_LEN:   old_len_reg   <= cfg_data[LW-1:0];
                irt_pkg::REG_NEW_FIRST: new_first_reg <= cfg_data;
                irt_pkg::REG_NEW_LAST:  new_last_reg  <= cfg_data;
                irt_pkg::REG_NEW_LEN:   new_len_reg   <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // saturate name lengths
    assign old_len_c = (old_len_reg > LEN_MAX) ? LEN_MAX : old_len_reg;
    assign new_len_c = (new_len_reg > LEN_MAX) ? LEN_MAX : new_len_reg;
    assign old_chars = {old_last_reg, old_first_reg};
    assign new_chars = {new_last_reg, new_first_reg};

    assign text_ready = (state_reg == ST_IDLE);
    assign text_acc   = text_valid && text_ready;
    assign slot_free  = !out_valid_reg || result_ready;
    assign push       = (state_reg == ST_EMIT) && slot_free;
    assign b          = text_beat.text_byte;

    assign is_word = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
                  || ((b >= 8'h30) && (b <= 8'h39)) || (b == irt_pkg::CH_UNDERSCORE);

    // lex one byte: what the chain emits, whether the byte follows, next state
    always_comb
    begin
        logic normal_v;
        normal_v = 1'b0;
        mode_v   = mode_reg;
        len_v    = word_len_reg;
        mm_v     = may_match_reg;
        cnt_v    = '0;
        rep_v    = 1'b0;
        hasb_v   = 1'b0;
        write_v  = 1'b0;
        load_v   = 1'b0;

        unique case (mode_reg)
            MODE_COMMENT:
            begin
                hasb_v = 1'b1;
                if ((b == irt_pkg::CH_NEWLINE) || (b == irt_pkg::CH_NUL))
                begin
                    mode_v = MODE_NORMAL;
                end
            end
            MODE_STRING:
            begin
                hasb_v = 1'b1;
                if ((b == irt_pkg::CH_NEWLINE) || (b == irt_pkg::CH_NUL)
                    || (b == irt_pkg::CH_QUOTE))
                begin
                    mode_v = MODE_NORMAL;
                end
            end
            MODE_SLASH:
            begin
                if (b == irt_pkg::CH_SLASH)
                begin
                    hasb_v = 1'b1;
                    mode_v = MODE_COMMENT;
                end
                else
                begin
                    mode_v   = MODE_NORMAL;
                    normal_v = 1'b1;
                end
            end
            MODE_NORMAL: normal_v = 1'b1;
            default:     normal_v = 1'b1;
        endcase

        if (normal_v)
        begin
            if (is_word)
            begin
                if (mm_v && (len_v < old_len_c) && (b == old_chars[len_v[3:0]]))
                begin
                    // still a candidate: hold the byte
                    write_v = 1'b1;
                    len_v   = LW'(len_v + LW'(1));
                end
                else if (mm_v)
                begin
                    cnt_v  = len_v;
                    mm_v   = 1'b0;
                    hasb_v = 1'b1;
                end
                else
                begin
                    hasb_v = 1'b1;
                end
            end
            else
            begin
                if (mm_v && (len_v != '0))
                begin
                    if (len_v == old_len_c)
                    begin
                        cnt_v  = new_len_c;
                        rep_v  = 1'b1;
                        load_v = 1'b1;
                    end
                    else
                    begin
                        cnt_v = len_v;
                    end
                end
                len_v  = '0;
                mm_v   = 1'b1;
                hasb_v = 1'b1;
                if (b == irt_pkg::CH_SLASH)
                begin
                    mode_v = MODE_SLASH;
                end
                else if (b == irt_pkg::CH_QUOTE)
                begin
                    mode_v = MODE_STRING;
                end
            end
        end

        // final byte: close any held word
        if (text_beat.end_of_text)
        begin
            if (mm_v && (len_v != '0))
            begin
                if (len_v == old_len_c)
                begin
                    cnt_v  = new_len_c;
                    rep_v  = 1'b1;
                    load_v = 1'b1;
                end
                else
                begin
                    cnt_v = len_v;
                end
            end
            len_v  = '0;
            mm_v   = 1'b1;
            mode_v = MODE_NORMAL;
        end
    end

    // chain of cells, shifting toward cell 0
    for (genvar gi = 0; gi < irt_pkg::NAME_MAX; gi++)
    begin : g_chain
        logic [7:0] nb;
        if (gi == irt_pkg::NAME_MAX - 1)
        begin : g_tail
            assign nb = irt_pkg::CH_NUL;
        end
        else
        begin : g_mid
            assign nb = cell_out[gi + 1];
        end

        assign cell_ctrl[gi].load  = text_acc && load_v;
        assign cell_ctrl[gi].write = text_acc && write_v && (word_len_reg[3:0] == 4'(gi));
        assign cell_ctrl[gi].shift = push && (cnt_reg != '0);

        irt_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[gi]),
            .name_byte (new_chars[gi]),
            .text_byte (b),
            .next_byte (nb),
            .cell_byte (cell_out[gi])
        );
    end

    // sequencer: state, lexer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_NORMAL;
            word_len_reg  <= '0;
            may_match_reg <= 1'b1;
            cnt_reg       <= '0;
            rep_reg       <= 1'b0;
            has_b_reg     <= 1'b0;
            b_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_beat_reg  <= '0;
        end
        else
        begin
            // output stage fills on a push, empties when its beat is taken
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (text_acc)
                    begin
                        mode_reg      <= mode_v;
                        word_len_reg  <= len_v;
                        may_match_reg <= mm_v;
                        cnt_reg       <= cnt_v;
                        rep_reg       <= rep_v;
                        has_b_reg     <= hasb_v;
                        b_reg         <= b;
                        if ((cnt_v != '0) || hasb_v)
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (push)
                    begin
                        if (cnt_reg != '0)
                        begin
                            out_beat_reg.out_byte <= cell_out[0];
                            out_beat_reg.replaced <= rep_reg;
                            out_beat_reg.run_last <= (cnt_reg == LW'(1)) && !has_b_reg;
                            cnt_reg               <= LW'(cnt_reg - LW'(1));
                            if ((cnt_reg == LW'(1)) && !has_b_reg)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        else
                        begin
                            out_beat_reg.out_byte <= b_reg;
                            out_beat_reg.replaced <= 1'b0;
                            out_beat_reg.run_last <= 1'b1;
                            has_b_reg             <= 1'b0;
                            state_reg             <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result_beat  = out_beat_reg;

    // taking input means nothing of the previous item is left to emit
    `IRT_ASSERT_NOW(a_idle_drained, clk, rst_n, text_ready, (cnt_reg == '0) && !has_b_reg)
    // the emitter never sits with nothing to send
    `IRT_ASSERT_NOW(a_emit_has_work, clk, rst_n, state_reg == ST_EMIT,
        (cnt_reg != '0) || has_b_reg)
    // a held word never outgrows the cell chain
    `IRT_ASSERT_NOW(a_word_fits, clk, rst_n, 1'b1, word_len_reg <= LEN_MAX)
    // a final byte leaves no word held and the lexer in plain text
    `IRT_ASSERT_NEXT(a_eot_clears, clk, rst_n, text_acc && text_beat.end_of_text,
        (word_len_reg == '0) && may_match_reg && (mode_reg == MODE_NORMAL))

endmodule

`default_nettype wire

// File: verif/tb_identifier_rename_in_text.sv
// self-checking testbench of the whole-word identifier rename block
`default_nettype none

module tb_identifier_rename_in_text;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 4;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 50;
    // a word end drains up to sixteen beats out of the cell chain and its ending byte, plus the output stage
    localparam int SETTLE_CYCLES = 24;
    // far above the slowest run: every byte with a long gap and every beat a long stall
    localparam longint LIMIT_NS  = 64'd100_000_000;

    // predicts the rewritten stream and holds the beats still owed by the block
    class rename_scoreboard;
        typedef enum logic [2:0] {
            LEX_NORMAL,
            LEX_SLASH,
            LEX_COMMENT,
            LEX_STRING
        } lex_mode_t;

        logic [127:0]       old_name;
        logic [127:0]       new_name;
        logic [4:0]         old_len;
        logic [4:0]         new_len;
        lex_mode_t          mode;
        logic [7:0]         held [16];
        int unsigned        held_len;
        bit                 may_match;
        irt_pkg::out_beat_t step_beats [$];
        irt_pkg::out_beat_t owed_beats [$];
        int                 errors;

        function new();
            old_name  = '0;
            new_name  = '0;
            old_len   = 5'd1;
            new_len   = 5'd0;
            mode      = LEX_NORMAL;
            held_len  = 0;
            may_match = 1'b1;
            errors    = 0;
            foreach (held[i])
                held[i] = '0;
        endfunction

        function int unsigned clamp(logic [4:0] len);
            return (len > irt_pkg::NAME_MAX) ? irt_pkg::NAME_MAX : int'(len);
        endfunction

        function void write_reg(logic [2:0] index, logic [63:0] data);
            case (index)
                irt_pkg::REG_OLD_FIRST: old_name[63:0]   = data;
                irt_pkg::REG_OLD_LAST:  old_name[127:64] = data;
                irt_pkg::REG_OLD_LEN:   old_len          = data[4:0];
                irt_pkg::REG_NEW_FIRST: new_name[63:0]   = data;
                irt_pkg::REG_NEW_LAST:  new_name[127:64] = data;
                irt_pkg::REG_NEW_LEN:   new_len          = data[4:0];
                default: ;
            endcase
        endfunction

        function void emit(logic [7:0] b, logic rep);
            irt_pkg::out_beat_t beat;
            beat.out_byte = b;
            beat.run_last = 1'b0;
            beat.replaced = rep;
            step_beats.push_back(beat);
        endfunction

        function void flush_held();
            for (int i = 0; i < held_len; i++)
                emit(held[i], 1'b0);
        endfunction

        // word ended: new name if the whole old name was seen, else the held bytes
        function void close_word();
            if (may_match && held_len > 0) begin
                if (held_len == clamp(old_len)) begin
                    for (int i = 0; i < clamp(new_len); i++)
                        emit(new_name[8*i +: 8], 1'b1);
                end
                else begin
                    flush_held();
                end
            end
            held_len  = 0;
            may_match = 1'b1;
        endfunction

        function void lex_plain(logic [7:0] b);
            bit word;
            word = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                   (b >= "0" && b <= "9") || b == irt_pkg::CH_UNDERSCORE;
            if (word) begin
                if (may_match) begin
                    if (held_len < clamp(old_len) && b == old_name[8*held_len +: 8]) begin
                        held[held_len] = b;
                        held_len++;
                        return;
                    end
                    flush_held();
                    may_match = 1'b0;
                end
                emit(b, 1'b0);
                return;
            end
            close_word();
            if (b == irt_pkg::CH_SLASH)
                mode = LEX_SLASH;
            else if (b == irt_pkg::CH_QUOTE)
                mode = LEX_STRING;
            emit(b, 1'b0);
        endfunction

        function void note_text(irt_pkg::in_beat_t beat);
            logic [7:0]         b;
            irt_pkg::out_beat_t last;
            b = beat.text_byte;
            step_beats.delete();
            case (mode)
                LEX_COMMENT:
                begin
                    emit(b, 1'b0);
                    if (b == irt_pkg::CH_NEWLINE || b == irt_pkg::CH_NUL)
                        mode = LEX_NORMAL;
                end
                LEX_STRING:
                begin
                    emit(b, 1'b0);
                    if (b == irt_pkg::CH_NEWLINE || b == irt_pkg::CH_NUL
                        || b == irt_pkg::CH_QUOTE)
                        mode = LEX_NORMAL;
                end
                LEX_SLASH:
                begin
                    if (b == irt_pkg::CH_SLASH) begin
                        emit(b, 1'b0);
                        mode = LEX_COMMENT;
                    end
                    else begin
                        mode = LEX_NORMAL;
                        lex_plain(b);
                    end
                end
                default:
                begin
                    mode = LEX_NORMAL;
                    lex_plain(b);
                end
            endcase
            if (beat.end_of_text) begin
                close_word();
                mode = LEX_NORMAL;
            end
            if (step_beats.size() > 0) begin
                last = step_beats.pop_back();
                last.run_last = 1'b1;
                step_beats.push_back(last);
            end
            foreach (step_beats[i])
                owed_beats.push_back(step_beats[i]);
        endfunction

        function void check_result(irt_pkg::out_beat_t got);
            irt_pkg::out_beat_t want;
            if (owed_beats.size() == 0) begin
                $error("result beat %h arrived with nothing owed", got);
                errors++;
                return;
            end
            want = owed_beats.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte mismatch: expected %h, actual %h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last mismatch: expected %b, actual %b", want.run_last, got.run_last);
                errors++;
            end
            if (got.replaced !== want.replaced) begin
                $error("replaced mismatch: expected %b, actual %b", want.replaced, got.replaced);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               text_valid;
    logic               text_ready;
    irt_pkg::in_beat_t  text_beat;
    logic               result_valid;
    logic               result_ready;
    irt_pkg::out_beat_t result_beat;

    // set for phases that run with no idling on either side
    bit quiet;
    rename_scoreboard sb;

    identifier_rename_in_text dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_beat    (text_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard stop in case a beat never comes
    initial
    begin
        #(LIMIT_NS);
        $display("tb_identifier_rename_in_text NOT OK");
        $finish;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r < 62)
            return 8'("0" + r - 52);
        return irt_pkg::CH_UNDERSCORE;
    endfunction

    function automatic logic [127:0] rand_ident_name();
        logic [127:0] nm;
        for (int i = 0; i < 16; i++)
            nm[8*i +: 8] = rand_word_char();
        return nm;
    endfunction

    function automatic logic [127:0] rand_bits_128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // all sampling happens here at the rising edge, on pre-edge values,
    // so the order of processes inside the time step does not matter
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (text_valid && text_ready)
                sb.note_text(text_beat);
            if (result_valid && result_ready)
                sb.check_result(result_beat);
        end
    end

    // result side: ready drops for random stretches
    initial
    begin
        int stall;
        stall        = 0;
        result_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                result_ready <= 1'b0;
                stall--;
            end
            else begin
                result_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // valid stays up across back-to-back writes and is lowered once after the last
    task automatic configure(input logic [127:0] old_nm, input logic [4:0] old_l,
                             input logic [127:0] new_nm, input logic [4:0] new_l);
        logic [63:0] vals [6];
        logic [2:0]  idx [6];
        vals = '{old_nm[63:0], old_nm[127:64], {59'd0, old_l},
                 new_nm[63:0], new_nm[127:64], {59'd0, new_l}};
        idx  = '{irt_pkg::REG_OLD_FIRST, irt_pkg::REG_OLD_LAST, irt_pkg::REG_OLD_LEN,
                 irt_pkg::REG_NEW_FIRST, irt_pkg::REG_NEW_LAST, irt_pkg::REG_NEW_LEN};
        for (int i = 0; i < 6; i++) begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one text beat; with no gap valid simply stays high for the next byte
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int                gap;
        irt_pkg::in_beat_t beat;
        gap              = pick_gap();
        beat.text_byte   = b;
        beat.end_of_text = eot;
        if (gap > 0) begin
            @(negedge clk);
            text_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        text_valid <= 1'b1;
        text_beat  <= beat;
        do @(posedge clk); while (!text_ready);
    endtask

    task automatic send_text(input string s, input bit eot_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_last && i == s.len() - 1);
    endtask

    // held word bytes give no beat, so wait out the chain after the queue empties
    task automatic wait_idle();
        @(negedge clk);
        text_valid <= 1'b0;
        while (sb.owed_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one lexical piece of random text; half of them aimed at the old name
    task automatic send_token(inout int sent);
        logic [7:0]  chunk [$];
        int unsigned olen;
        int          r;
        int          n;
        olen = sb.clamp(sb.old_len);
        r    = $urandom_range(0, 99);
        if (olen == 0 && r < 50)
            r = 55;
        if (r < 30) begin
            // exact old name
            for (int i = 0; i < olen; i++)
                chunk.push_back(sb.old_name[8*i +: 8]);
        end
        else if (r < 42) begin
            // partial name then a word byte that may break it
            n = $urandom_range(1, olen);
            for (int i = 0; i < n; i++)
                chunk.push_back(sb.old_name[8*i +: 8]);
            chunk.push_back(rand_word_char());
        end
        else if (r < 50) begin
            // old name run on into a longer word
            for (int i = 0; i < olen; i++)
                chunk.push_back(sb.old_name[8*i +: 8]);
            n = $urandom_range(1, 2);
            repeat (n) chunk.push_back(rand_word_char());
        end
        else if (r < 60) begin
            n = $urandom_range(1, 6);
            repeat (n) chunk.push_back(rand_word_char());
        end
        else if (r < 75) begin
            case ($urandom_range(0, 5))
                0: chunk.push_back(" ");
                1: chunk.push_back(irt_pkg::CH_NEWLINE);
                2: chunk.push_back(irt_pkg::CH_NUL);
                3: chunk.push_back(";");
                4: chunk.push_back("(");
                default: chunk.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        else if (r < 84) begin
            // line comment, closed by newline or nul
            chunk.push_back(irt_pkg::CH_SLASH);
            chunk.push_back(irt_pkg::CH_SLASH);
            n = $urandom_range(0, 5);
            repeat (n) chunk.push_back($urandom_range(0, 1) ? rand_word_char()
                                                            : 8'($urandom_range(0, 255)));
            chunk.push_back($urandom_range(0, 3) == 0 ? irt_pkg::CH_NUL
                                                      : irt_pkg::CH_NEWLINE);
        end
        else if (r < 92) begin
            // quoted text, closed by quote, newline or nul
            chunk.push_back(irt_pkg::CH_QUOTE);
            n = $urandom_range(0, 5);
            repeat (n) chunk.push_back($urandom_range(0, 1) ? rand_word_char()
                                                            : 8'($urandom_range(0, 255)));
            case ($urandom_range(0, 3))
                0: chunk.push_back(irt_pkg::CH_NEWLINE);
                1: chunk.push_back(irt_pkg::CH_NUL);
                default: chunk.push_back(irt_pkg::CH_QUOTE);
            endcase
        end
        else if (r < 96) begin
            chunk.push_back(irt_pkg::CH_SLASH);
        end
        else begin
            n = $urandom_range(1, 4);
            repeat (n) chunk.push_back(8'($urandom_range(0, 255)));
        end
        foreach (chunk[i]) begin
            send_byte(chunk[i], $urandom_range(0, 99) < 3);
            sent++;
        end
    endtask

    initial
    begin
        logic [127:0] old_nm;
        logic [127:0] new_nm;
        logic [4:0]   old_l;
        logic [4:0]   new_l;
        int           sent;

        sb         = new();
        quiet      = 1'b0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        text_valid = 1'b0;
        text_beat  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed: old name "foo", new name "barbaz"; bytes sit lowest first,
        // so the literals read backwards
        configure({104'd0, "oof"}, 5'd3, {80'd0, "zabrab"}, 5'd6);
        send_text("foo ", 1'b0);     // whole word replaced, byte after it lexed
        send_text("fox+", 1'b0);     // mismatch flushes the held prefix
        send_text("/foo/", 1'b0);    // single slash, then a word right after it
        send_text("/f\n", 1'b0);     // second slash opens a comment, newline closes it
        send_text("\"o\"", 1'b0);    // quoted text passes as is
        send_byte(8'hFF, 1'b0);
        send_byte(irt_pkg::CH_NUL, 1'b0);
        send_text("fo", 1'b1);       // end of text flushes a partial word
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            quiet  = (p % 4 == 3);
            old_nm = rand_ident_name();
            new_nm = rand_bits_128();
            case (p)
                0:
                begin
                    // one-byte name deleted wherever it stands alone
                    old_l = 5'd1;
                    new_l = 5'd0;
                end
                1:
                begin
                    old_l = 5'd16;
                    new_l = 5'd16;
                end
                2:
                begin
                    // lengths above the buffer depth saturate
                    old_l = 5'd31;
                    new_l = 5'd31;
                end
                3:
                begin
                    // empty old name: nothing can ever match
                    old_l = 5'd0;
                    new_l = 5'($urandom_range(0, 16));
                end
                4:
                begin
                    old_nm = rand_bits_128();
                    old_l  = 5'($urandom_range(0, 31));
                    new_l  = 5'($urandom_range(0, 31));
                end
                default:
                begin
                    old_l = 5'($urandom_range(1, 5));
                    new_l = 5'($urandom_range(0, 16));
                end
            endcase
            configure(old_nm, old_l, new_nm, new_l);
            sent = 0;
            while (sent < PHASE_ITEMS)
                send_token(sent);
            // close the phase so no word is pending across a register change
            send_byte(" ", 1'b1);
            wait_idle();
        end

        quiet = 1'b0;
        if (sb.errors == 0)
            $display("tb_identifier_rename_in_text OK");
        else
            $display("tb_identifier_rename_in_text NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
